[design/tfd_pkg.sv]
// Shared constants, types and checksum helper for the telemetry frame decoder.
package tfd_pkg;

  // Line framing bytes.
  localparam logic [7:0] SOF_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE = 8'h7D;
  localparam logic [7:0] ESC_XOR  = 8'h20;

  // Register reset values.
  localparam logic [7:0] OWN_ID_RESET   = 8'h00;
  localparam logic [7:0] DATA_HDR_RESET = 8'h10;

  // Configuration register indexes.
  localparam logic CFG_OWN_ID   = 1'b0;
  localparam logic CFG_DATA_HDR = 1'b1;

  // Event codes reported with each item.
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_POLL   = 3'd1,
    EV_OK     = 3'd2,
    EV_BADSUM = 3'd3,
    EV_RESYNC = 3'd4
  } event_t;

  // One result item.
  typedef struct packed {
    event_t      event_res;
    logic [7:0]  station_id;
    logic [15:0] app_id;
    logic [31:0] payload;
  } result_t;

  // Eight-bit sum with end-around carry.
  function automatic logic [7:0] add_eac(input logic [7:0] acc, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, acc} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

[design/telemetry_frame_decoder_unit.sv]
// Top level of the telemetry frame decoder: deframer, checksum and result buffer.
//
//   channel   signals                               direction  width
//   input     in_valid/in_ready, rx_byte            in         8
//   result    out_valid/out_ready, event_res,       out        3/8/16/32
//             station_id, app_id, payload
//   config    cfg_we, cfg_index, cfg_data           in         1/1/8
//
// The parser state is updated at the accepting edge and the result is registered at the
// same edge, one result per item.
// Sustained rate is one item per cycle while the result buffer is not full.
// A two-entry result buffer (output register plus skid register) lets a new item be
// accepted while a result still waits; in_ready drops only when both are full.
// Reset (synchronous, rst high) returns the parser to waiting for a start byte,
// clears the frame registers and empties the result buffer.
module telemetry_frame_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  event_res,
  output logic [7:0]  station_id,
  output logic [15:0] app_id,
  output logic [31:0] payload,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'd0,
    ST_ID   = 4'd1,
    ST_HDR  = 4'd2,
    ST_APP0 = 4'd3,
    ST_APP1 = 4'd4,
    ST_DAT0 = 4'd5,
    ST_DAT1 = 4'd6,
    ST_DAT2 = 4'd7,
    ST_DAT3 = 4'd8,
    ST_CHK  = 4'd9
  } state_t;

  // Configuration registers.
  logic [7:0] own_station_id;
  logic [7:0] data_header_byte;

  // Parser state.
  state_t      state, state_next;
  logic        unstuff_pending, unstuff_pending_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [7:0]  frame_station_id, frame_station_id_next;
  logic [15:0] frame_app_id, frame_app_id_next;
  logic [31:0] frame_payload, frame_payload_next;

  // Result buffer.
  tfd_pkg::result_t out_item, skid_item, res;
  logic             skid_valid;

  logic          in_fire, out_fire;
  logic          is_sof, escaped, in_body, take_escape, do_resync;
  logic [7:0]    b;
  tfd_pkg::event_t ev;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Byte classification and unstuffing.
  assign is_sof      = (rx_byte == tfd_pkg::SOF_BYTE);
  assign escaped     = unstuff_pending;
  assign b           = unstuff_pending ? (rx_byte ^ tfd_pkg::ESC_XOR) : rx_byte;
  assign in_body     = (state == ST_APP0) || (state == ST_APP1) || (state == ST_DAT0) ||
                       (state == ST_DAT1) || (state == ST_DAT2) || (state == ST_DAT3) ||
                       (state == ST_CHK);
  assign take_escape = !escaped && (b == tfd_pkg::ESC_BYTE) && in_body;

  // Parser next state for the byte on the input.
  always_comb begin
    state_next            = state;
    unstuff_pending_next  = unstuff_pending;
    running_sum_next      = running_sum;
    frame_station_id_next = frame_station_id;
    frame_app_id_next     = frame_app_id;
    frame_payload_next    = frame_payload;
    ev                    = tfd_pkg::EV_NONE;
    do_resync             = 1'b0;
    if (is_sof) begin
      state_next           = ST_ID;
      unstuff_pending_next = 1'b0;
    end else begin
      unstuff_pending_next = 1'b0;
      if (take_escape) begin
        unstuff_pending_next = 1'b1;
      end else begin
        unique case (state)
          ST_ID: begin
            frame_station_id_next = b;
            frame_app_id_next     = '0;
            frame_payload_next    = '0;
            state_next            = ST_HDR;
            if (b == own_station_id) ev = tfd_pkg::EV_POLL;
          end
          ST_HDR: begin
            if (b == data_header_byte) begin
              running_sum_next = b;
              state_next       = ST_APP0;
            end else begin
              do_resync = 1'b1;
            end
          end
          ST_APP0: begin
            frame_app_id_next[7:0] = b;
            state_next             = ST_APP1;
          end
          ST_APP1: begin
            frame_app_id_next[15:8] = b;
            state_next              = ST_DAT0;
          end
          ST_DAT0: begin
            frame_payload_next[7:0] = b;
            state_next              = ST_DAT1;
          end
          ST_DAT1: begin
            frame_payload_next[15:8] = b;
            state_next               = ST_DAT2;
          end
          ST_DAT2: begin
            frame_payload_next[23:16] = b;
            state_next                = ST_DAT3;
          end
          ST_DAT3: begin
            frame_payload_next[31:24] = b;
            state_next                = ST_CHK;
          end
          ST_CHK: begin
            if (b == ~running_sum) begin
              state_next = ST_IDLE;
              ev         = tfd_pkg::EV_OK;
            end else begin
              ev = tfd_pkg::EV_BADSUM;
            end
          end
          default: begin
            // Any byte while waiting for a start byte is stray.
            do_resync = 1'b1;
          end
        endcase
      end
      if (do_resync) begin
        state_next            = ST_IDLE;
        unstuff_pending_next  = 1'b0;
        frame_station_id_next = '0;
        frame_app_id_next     = '0;
        frame_payload_next    = '0;
        ev                    = tfd_pkg::EV_RESYNC;
      end
      // App id and payload bytes, and a wrong check byte, add into the sum.
      if (!unstuff_pending_next &&
          ((state_next == ST_APP1) || (state_next == ST_DAT0) || (state_next == ST_DAT1) ||
           (state_next == ST_DAT2) || (state_next == ST_DAT3) || (state_next == ST_CHK))) begin
        running_sum_next = tfd_pkg::add_eac(running_sum_next, b);
      end
    end
  end

  // Result of this item.
  always_comb begin
    res.event_res  = ev;
    res.station_id = frame_station_id_next;
    res.app_id     = frame_app_id_next;
    res.payload    = frame_payload_next;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_station_id   <= tfd_pkg::OWN_ID_RESET;
      data_header_byte <= tfd_pkg::DATA_HDR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tfd_pkg::CFG_OWN_ID:   own_station_id   <= cfg_data;
        tfd_pkg::CFG_DATA_HDR: data_header_byte <= cfg_data;
        default:               own_station_id   <= own_station_id;
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      unstuff_pending  <= 1'b0;
      running_sum      <= '0;
      frame_station_id <= '0;
      frame_app_id     <= '0;
      frame_payload    <= '0;
    end else if (in_fire) begin
      state            <= state_next;
      unstuff_pending  <= unstuff_pending_next;
      running_sum      <= running_sum_next;
      frame_station_id <= frame_station_id_next;
      frame_app_id     <= frame_app_id_next;
      frame_payload    <= frame_payload_next;
    end
  end

  // Output register with a skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_fire) begin
      if (out_valid && !out_ready) begin
        skid_item  <= res;
        skid_valid <= 1'b1;
      end else begin
        out_item  <= res;
        out_valid <= 1'b1;
      end
    end else if (out_fire) begin
      if (skid_valid) begin
        out_item   <= skid_item;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign event_res  = out_item.event_res;
  assign station_id = out_item.station_id;
  assign app_id     = out_item.app_id;
  assign payload    = out_item.payload;

  // The skid register is only occupied behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds an item while the output register is empty");

  // A pending unstuff only exists inside the frame body.
  a_pending_in_body: assert property (@(posedge clk) disable iff (rst)
    unstuff_pending |-> in_body)
    else $error("unstuff pending outside the frame body");

  // A start byte always restarts the frame at the station id.
  a_sof_restarts: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_sof) |=> (state == ST_ID) && !unstuff_pending)
    else $error("start byte did not restart the frame");

  // A stalled output keeps its item valid and stable.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

endmodule
